[rtl/core/etsq_pkg.sv]
`timescale 1ns / 1ps

package etsq_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int IDX_W        = $clog2(NUM_SLOTS);
  localparam int CNT_W        = $clog2(NUM_SLOTS + 1);
  localparam int PS_W         = 64;
  localparam int STEP_W       = 32;
  localparam int KEY_W        = PS_W + 2 * STEP_W;
  localparam int SLOT_INDEX_W = 4;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic pop_remove;
    logic pop_fail;
    logic scan_run;
    logic commit;
  } etsq_cmd_t;

  typedef struct packed {
    logic op_pop;
    logic pop_empty;
    logic scan_last;
    logic out_free;
  } etsq_sts_t;

  // The result port carries the low bits of the slot number.
  function automatic logic [SLOT_INDEX_W-1:0] to_slot_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_INDEX_W-1:0] ext;
    ext = {{SLOT_INDEX_W{1'b0}}, idx};
    return ext[SLOT_INDEX_W-1:0];
  endfunction

endpackage

[rtl/core/event_time_slot_queue.sv]
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// input    in_valid / in_ready  op, time_ps, delta_step, eps_step
// output   out_valid/out_ready  slot_index, slot_time_ps, slot_delta, slot_eps,
//                               created_new, status
//
// An insert or a pop of a non-empty pool scans all NUM_SLOTS slot times, one a cycle;
// a pop of an empty pool skips the scan. A new beat is taken only once the last result
// has been committed to the output register.
// Reset is synchronous; no clearing pass is needed.
// A finished item waits until the output register is free; the next beat is accepted
// while a result waits there.
module event_time_slot_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic [etsq_pkg::PS_W-1:0]             time_ps,
  input  logic [etsq_pkg::STEP_W-1:0]           delta_step,
  input  logic [etsq_pkg::STEP_W-1:0]           eps_step,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [etsq_pkg::SLOT_INDEX_W-1:0]     slot_index,
  output logic [etsq_pkg::PS_W-1:0]             slot_time_ps,
  output logic [etsq_pkg::STEP_W-1:0]           slot_delta,
  output logic [etsq_pkg::STEP_W-1:0]           slot_eps,
  output logic                                  created_new,
  output logic [1:0]                            status
);

  etsq_pkg::etsq_cmd_t cmd;
  etsq_pkg::etsq_sts_t sts;

  etsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  etsq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_op       (op),
    .in_time_ps  (time_ps),
    .in_delta    (delta_step),
    .in_eps      (eps_step),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_index   (slot_index),
    .out_time_ps (slot_time_ps),
    .out_delta   (slot_delta),
    .out_eps     (slot_eps),
    .out_created (created_new),
    .out_status  (status)
  );

endmodule

[rtl/core/etsq_ctrl.sv]
`timescale 1ns / 1ps

module etsq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  etsq_pkg::etsq_sts_t sts,
  output etsq_pkg::etsq_cmd_t cmd
);

  etsq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etsq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      etsq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = etsq_pkg::S_CHECK;
        end
      end
      etsq_pkg::S_CHECK: begin
        if (sts.op_pop && sts.pop_empty) begin
          cmd.pop_fail = 1'b1;
          state_next   = etsq_pkg::S_DONE;
        end else begin
          cmd.pop_remove = sts.op_pop;
          state_next     = etsq_pkg::S_SCAN;
        end
      end
      etsq_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_last) begin
          state_next = etsq_pkg::S_DONE;
        end
      end
      etsq_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = etsq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = etsq_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("result committed while output register is occupied");

  a_scan_follows_check: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd.scan_run) |-> $past(state) == etsq_pkg::S_CHECK)
    else $error("scan started without a check step");

  a_capture_then_check: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == etsq_pkg::S_CHECK)
    else $error("accepted beat not followed by check step");
`endif

endmodule

[rtl/core/etsq_dp.sv]
`timescale 1ns / 1ps

module etsq_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_op,
  input  logic [etsq_pkg::PS_W-1:0]             in_time_ps,
  input  logic [etsq_pkg::STEP_W-1:0]           in_delta,
  input  logic [etsq_pkg::STEP_W-1:0]           in_eps,
  input  etsq_pkg::etsq_cmd_t                   cmd,
  output etsq_pkg::etsq_sts_t                   sts,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [etsq_pkg::SLOT_INDEX_W-1:0]     out_index,
  output logic [etsq_pkg::PS_W-1:0]             out_time_ps,
  output logic [etsq_pkg::STEP_W-1:0]           out_delta,
  output logic [etsq_pkg::STEP_W-1:0]           out_eps,
  output logic                                  out_created,
  output logic [1:0]                            out_status
);

  localparam int N     = etsq_pkg::NUM_SLOTS;
  localparam int IDX_W = etsq_pkg::IDX_W;
  localparam int CNT_W = etsq_pkg::CNT_W;

  // Slot times and the stack of freed slots. A slot time is only used
  // while its in-use bit is set, so the array needs no clearing.
  etsq_pkg::key_t   slot_mem [N];
  logic [IDX_W-1:0] free_stack [N];

  logic [N-1:0]     in_use;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] fresh_count;
  logic [CNT_W-1:0] event_count;
  logic [IDX_W-1:0] earliest_index;
  etsq_pkg::key_t   earliest_key;

  etsq_pkg::op_t    op_q;
  etsq_pkg::key_t   key_q;
  logic             fail_q;
  logic [IDX_W-1:0] pop_idx_q;
  etsq_pkg::key_t   pop_key_q;
  logic [IDX_W-1:0] free_top_q;

  logic [CNT_W-1:0] scan_cnt;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  etsq_pkg::key_t   rd_key_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx;
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  etsq_pkg::key_t   best_key;

  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] fs_rd_addr;
  logic             scan_issue;
  logic             rd_live;

  logic [IDX_W-1:0]  res_idx;
  etsq_pkg::key_t    res_key;
  logic              res_new;
  etsq_pkg::status_t res_status;
  logic              alloc_free;
  logic              alloc_fresh;
  logic              alloc;
  logic [IDX_W-1:0]  new_idx;
  logic              earlier;
  logic              pop_commit;

  assign scan_addr  = scan_cnt[IDX_W-1:0];
  assign scan_issue = cmd.scan_run && (scan_cnt < CNT_W'(N));
  assign fs_rd_addr = IDX_W'(free_count - 1'b1);
  assign rd_live    = rd_vld_q && in_use[rd_idx_q];

  assign sts.op_pop    = (op_q == etsq_pkg::OP_POP);
  assign sts.pop_empty = (event_count == '0) || !in_use[earliest_index];
  assign sts.scan_last = (scan_cnt == CNT_W'(N));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    rd_key_q   <= slot_mem[scan_addr];
    free_top_q <= free_stack[fs_rd_addr];
    if (cmd.commit && alloc) begin
      slot_mem[new_idx] <= key_q;
    end
    if (cmd.pop_remove && (free_count < CNT_W'(N))) begin
      free_stack[free_count[IDX_W-1:0]] <= earliest_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= etsq_pkg::op_t'(in_op);
      key_q <= {in_time_ps, in_delta, in_eps};
    end
    if (cmd.pop_remove) begin
      pop_idx_q <= earliest_index;
      pop_key_q <= earliest_key;
    end
    rd_idx_q <= scan_addr;
  end

  // Insert looks for an equal live time; pop keeps the strictly smaller
  // live time so that ties go to the lowest index. The scan results hold
  // until the next beat is captured, so a stalled result stays intact.
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      scan_cnt   <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      hit_idx    <= '0;
      best_found <= 1'b0;
      best_idx   <= '0;
    end else begin
      if (scan_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      rd_vld_q <= scan_issue;
      if (rd_live && !hit_q && (rd_key_q == key_q)) begin
        hit_q   <= 1'b1;
        hit_idx <= rd_idx_q;
      end
      if (rd_live && (!best_found || (rd_key_q < best_key))) begin
        best_found <= 1'b1;
        best_idx   <= rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && rd_live && (!best_found || (rd_key_q < best_key))) begin
      best_key <= rd_key_q;
    end
  end

  always_comb begin
    res_idx     = '0;
    res_key     = '0;
    res_new     = 1'b0;
    res_status  = etsq_pkg::ST_OK;
    alloc_free  = 1'b0;
    alloc_fresh = 1'b0;
    new_idx     = free_top_q;
    if (op_q == etsq_pkg::OP_POP) begin
      if (fail_q) begin
        res_status = etsq_pkg::ST_EMPTY;
      end else begin
        res_idx = pop_idx_q;
        res_key = pop_key_q;
      end
    end else if (hit_q) begin
      res_idx = hit_idx;
      res_key = key_q;
    end else if (free_count != '0) begin
      alloc_free = 1'b1;
      res_idx    = new_idx;
      res_key    = key_q;
      res_new    = 1'b1;
    end else if (fresh_count < CNT_W'(N)) begin
      alloc_fresh = 1'b1;
      new_idx     = fresh_count[IDX_W-1:0];
      res_idx     = new_idx;
      res_key     = key_q;
      res_new     = 1'b1;
    end else begin
      res_status = etsq_pkg::ST_FULL;
    end
  end

  assign alloc      = alloc_free || alloc_fresh;
  assign earlier    = !in_use[earliest_index] || (key_q < earliest_key);
  assign pop_commit = cmd.commit && (op_q == etsq_pkg::OP_POP) && !fail_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use         <= '0;
      free_count     <= '0;
      fresh_count    <= '0;
      event_count    <= '0;
      earliest_index <= '0;
      fail_q         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        fail_q <= 1'b0;
      end else if (cmd.pop_fail) begin
        fail_q <= 1'b1;
      end
      if (cmd.pop_remove) begin
        in_use[earliest_index] <= 1'b0;
        event_count            <= event_count - 1'b1;
        if (free_count < CNT_W'(N)) begin
          free_count <= free_count + 1'b1;
        end
      end
      if (cmd.commit && alloc) begin
        in_use[new_idx] <= 1'b1;
        event_count     <= event_count + 1'b1;
        if (alloc_free) begin
          free_count <= free_count - 1'b1;
        end
        if (alloc_fresh) begin
          fresh_count <= fresh_count + 1'b1;
        end
        if (earlier) begin
          earliest_index <= new_idx;
        end
      end
      if (pop_commit) begin
        earliest_index <= best_found ? best_idx : '0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.commit && alloc && earlier) || (pop_commit && best_found)) begin
      earliest_key <= pop_commit ? best_key : key_q;
    end
    if (cmd.commit) begin
      out_index   <= etsq_pkg::to_slot_index(res_idx);
      out_time_ps <= res_key[etsq_pkg::KEY_W-1 -: etsq_pkg::PS_W];
      out_delta   <= res_key[2*etsq_pkg::STEP_W-1 -: etsq_pkg::STEP_W];
      out_eps     <= res_key[etsq_pkg::STEP_W-1:0];
      out_created <= res_new;
      out_status  <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_count_matches_bits: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(event_count))
    else $error("event count disagrees with in-use bits");

  a_slots_accounted: assert property (@(posedge clk) disable iff (rst)
    (free_count + event_count) == fresh_count)
    else $error("free and live slots do not add up to slots handed out");

  a_pop_frees_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_remove |=> !in_use[pop_idx_q])
    else $error("popped slot still marked in use");

  a_new_slot_live: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && alloc) |=> in_use[$past(new_idx)])
    else $error("allocated slot not marked in use");
`endif

endmodule

[verif/event_time_slot_queue_tb.sv]
`timescale 1ns / 1ps

module event_time_slot_queue_tb;
  import etsq_pkg::*;

  typedef struct packed {
    logic [3:0]        idx;
    logic [PS_W-1:0]   ps;
    logic [STEP_W-1:0] dl;
    logic [STEP_W-1:0] ep;
    logic              created;
    logic [1:0]        status;
  } slot_result_t;

  typedef struct {
    op_t               op;
    logic [PS_W-1:0]   ps;
    logic [STEP_W-1:0] dl;
    logic [STEP_W-1:0] ep;
    bit                fixed;
    slot_result_t      want;
  } stim_row_t;

  localparam slot_result_t NO_RESULT = '0;
  localparam int RANDOM_BEATS = 1228;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              op;
  logic [PS_W-1:0]   time_ps;
  logic [STEP_W-1:0] delta_step;
  logic [STEP_W-1:0] eps_step;
  logic              out_valid;
  logic              out_ready;
  logic [3:0]        slot_index;
  logic [PS_W-1:0]   slot_time_ps;
  logic [STEP_W-1:0] slot_delta;
  logic [STEP_W-1:0] slot_eps;
  logic              created_new;
  logic [1:0]        status;

  event_time_slot_queue dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .time_ps      (time_ps),
    .delta_step   (delta_step),
    .eps_step     (eps_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot_index   (slot_index),
    .slot_time_ps (slot_time_ps),
    .slot_delta   (slot_delta),
    .slot_eps     (slot_eps),
    .created_new  (created_new),
    .status       (status)
  );

  // Shadow copy of the slot pool.
  logic [PS_W-1:0]   pool_ps    [NUM_SLOTS];
  logic [STEP_W-1:0] pool_delta [NUM_SLOTS];
  logic [STEP_W-1:0] pool_eps   [NUM_SLOTS];
  bit                pool_live  [NUM_SLOTS];
  int                freed_slots [NUM_SLOTS];
  int                freed_depth;
  int                fresh_next;
  int                earliest_slot;
  int                live_slots;

  slot_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  key_t         recent_keys[$];
  int           err_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  function automatic key_t pool_key(int i);
    return {pool_ps[i], pool_delta[i], pool_eps[i]};
  endfunction

  function automatic slot_result_t apply_slot_op(op_t o, logic [PS_W-1:0] ps,
                                                 logic [STEP_W-1:0] dl,
                                                 logic [STEP_W-1:0] ep);
    slot_result_t r;
    key_t k;
    int i, hit, pick, top, best;
    bit found;
    r = NO_RESULT;
    k = {ps, dl, ep};
    top = earliest_slot;
    if (o == OP_INSERT) begin
      hit = -1;
      for (i = 0; i < NUM_SLOTS; i++)
        if (hit < 0 && pool_live[i] && pool_key(i) == k) hit = i;
      if (hit >= 0) begin
        r.idx = hit[3:0];
        r.ps = ps;
        r.dl = dl;
        r.ep = ep;
        r.status = ST_OK;
        return r;
      end
      // A freed slot is reused before a never-used one.
      if (freed_depth > 0) begin
        freed_depth--;
        pick = freed_slots[freed_depth];
      end else if (fresh_next < NUM_SLOTS) begin
        pick = fresh_next;
        fresh_next++;
      end else begin
        r.status = ST_FULL;
        return r;
      end
      if (!pool_live[top] || k < pool_key(top)) earliest_slot = pick;
      pool_live[pick] = 1'b1;
      pool_ps[pick] = ps;
      pool_delta[pick] = dl;
      pool_eps[pick] = ep;
      live_slots++;
      r.idx = pick[3:0];
      r.ps = ps;
      r.dl = dl;
      r.ep = ep;
      r.created = 1'b1;
      r.status = ST_OK;
      return r;
    end
    if (live_slots == 0 || !pool_live[top]) begin
      r.status = ST_EMPTY;
      return r;
    end
    r.idx = top[3:0];
    r.ps = pool_ps[top];
    r.dl = pool_delta[top];
    r.ep = pool_eps[top];
    r.status = ST_OK;
    pool_live[top] = 1'b0;
    pool_ps[top] = '0;
    pool_delta[top] = '0;
    pool_eps[top] = '0;
    live_slots--;
    if (freed_depth < NUM_SLOTS) begin
      freed_slots[freed_depth] = top;
      freed_depth++;
    end
    best = 0;
    found = 1'b0;
    for (i = 0; i < NUM_SLOTS; i++)
      if (pool_live[i] && (!found || pool_key(i) < pool_key(best))) begin
        best = i;
        found = 1'b1;
      end
    earliest_slot = best;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [PS_W-1:0] got,
                                 logic [PS_W-1:0] want);
    $display("%0t: %s mismatch, got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Drives one beat from a falling edge and returns at the falling edge after
  // it was accepted.
  task automatic send_beat(op_t o, logic [PS_W-1:0] ps, logic [STEP_W-1:0] dl,
                           logic [STEP_W-1:0] ep, bit fixed, slot_result_t want);
    slot_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    time_ps    <= ps;
    delta_step <= dl;
    eps_step   <= ep;
    do @(posedge clk); while (!in_ready);
    r = apply_slot_op(o, ps, dl, ep);
    pending_results.insert(pending_results.size(), fixed ? want : r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(op_t o, logic [PS_W-1:0] ps, logic [STEP_W-1:0] dl,
                                  logic [STEP_W-1:0] ep, bit fixed,
                                  slot_result_t want);
    stim_row_t row;
    row.op = o;
    row.ps = ps;
    row.dl = dl;
    row.ep = ep;
    row.fixed = fixed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Keys lean on recent ones and on a tiny range so that matches and ties in
  // the upper key parts are common.
  function automatic key_t pick_key();
    key_t k;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 3 && recent_keys.size() != 0)
      k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else if (mode <= 6)
      k = {64'($urandom_range(0, 3)), 32'($urandom_range(0, 3)),
           32'($urandom_range(0, 3))};
    else if (mode <= 8)
      k = {$urandom, $urandom, $urandom, $urandom};
    else
      k = {{64{1'($urandom_range(0, 1))}}, {32{1'($urandom_range(0, 1))}},
           {32{1'($urandom_range(0, 1))}}};
    recent_keys.insert(recent_keys.size(), k);
    if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    return k;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(slot_index), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (slot_index !== want.idx)
          report_mismatch("slot_index", 64'(slot_index), 64'(want.idx));
        if (slot_time_ps !== want.ps)
          report_mismatch("slot_time_ps", slot_time_ps, want.ps);
        if (slot_delta !== want.dl)
          report_mismatch("slot_delta", 64'(slot_delta), 64'(want.dl));
        if (slot_eps !== want.ep)
          report_mismatch("slot_eps", 64'(slot_eps), 64'(want.ep));
        if (created_new !== want.created)
          report_mismatch("created_new", 64'(created_new), 64'(want.created));
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("event_time_slot_queue_tb: errors");
    $finish;
  end

  initial begin
    int i, ph, insert_pct;
    key_t k;
    stim_row_t row;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    op = OP_INSERT;
    time_ps = '0;
    delta_step = '0;
    eps_step = '0;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    freed_depth = 0;
    fresh_next = 0;
    earliest_slot = 0;
    live_slots = 0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      pool_ps[i] = '0;
      pool_delta[i] = '0;
      pool_eps[i] = '0;
      pool_live[i] = 1'b0;
      freed_slots[i] = 0;
    end

    add_row(OP_POP, '0, '0, '0, 1, '{4'd0, 64'd0, 32'd0, 32'd0, 1'b0, ST_EMPTY});
    add_row(OP_INSERT, '0, '0, '0, 1, '{4'd0, 64'd0, 32'd0, 32'd0, 1'b1, ST_OK});
    add_row(OP_INSERT, '1, '1, '1, 1, '{4'd1, '1, '1, '1, 1'b1, ST_OK});
    add_row(OP_INSERT, '0, '0, '0, 1, '{4'd0, 64'd0, 32'd0, 32'd0, 1'b0, ST_OK});
    // Same picoseconds, ordered by delta and then by epsilon.
    add_row(OP_INSERT, 64'd5, 32'd0, 32'd1, 0, NO_RESULT);
    add_row(OP_INSERT, 64'd5, 32'd1, 32'd0, 0, NO_RESULT);
    add_row(OP_INSERT, 64'd5, 32'd0, 32'd0, 0, NO_RESULT);
    add_row(OP_POP, '0, '0, '0, 1, '{4'd0, 64'd0, 32'd0, 32'd0, 1'b0, ST_OK});
    // The freed slot holds time zero but must not match; it is reused instead.
    add_row(OP_INSERT, '0, '0, '0, 0, NO_RESULT);
    for (i = 0; i < 11; i++)
      add_row(OP_INSERT, 64'h8000_0000_0000_0000 >> (i * 6), 32'h8000_0000 >> (i * 3),
              32'hffff_ffff >> i, 0, NO_RESULT);
    add_row(OP_INSERT, 64'd7, 32'd7, 32'd7, 1, '{4'd0, 64'd0, 32'd0, 32'd0, 1'b0, ST_FULL});
    add_row(OP_INSERT, '1, '1, '1, 0, NO_RESULT);
    add_row(OP_POP, '0, '0, '0, 0, NO_RESULT);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[j]) begin
      row = directed_rows[j];
      send_beat(row.op, row.ps, row.dl, row.ep, row.fixed, row.want);
    end

    insert_pct = 50;
    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 19 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 19 : 0;
      for (i = 0; i < RANDOM_BEATS / 4; i++) begin
        // Shift the insert share now and then so the pool fills and drains.
        if (i % 40 == 0)
          case ($urandom_range(0, 3))
            0: insert_pct = 25;
            1: insert_pct = 50;
            2: insert_pct = 75;
            default: insert_pct = 92;
          endcase
        if ($urandom_range(0, 99) < insert_pct) begin
          k = pick_key();
          send_beat(OP_INSERT, k[KEY_W-1 -: PS_W], k[2*STEP_W-1 -: STEP_W],
                    k[STEP_W-1:0], 0, NO_RESULT);
        end else begin
          send_beat(OP_POP, {$urandom, $urandom}, $urandom, $urandom, 0, NO_RESULT);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("event_time_slot_queue_tb: clean");
    else
      $display("event_time_slot_queue_tb: errors");
    $finish;
  end

endmodule
